[hdl/midi_cc_learn_takeover_assert.svh]
// assertion macros for the controller learn map
`ifndef MIDI_CC_LEARN_TAKEOVER_ASSERT_SVH
`define MIDI_CC_LEARN_TAKEOVER_ASSERT_SVH

// same-cycle implication
`define MCL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("midi_cc_learn_takeover check failed");

// next-cycle implication
`define MCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("midi_cc_learn_takeover check failed");

`endif

[hdl/mcl_pkg.sv]
// types, constants and helpers of the controller learn map
package mcl_pkg;

  localparam int NumParams    = 256;
  localparam int ChannelSlots = 17;
  localparam int NumCc        = 128;
  localparam int PW           = 8;
  localparam int CcW          = 7;
  localparam int ChW          = 5;
  localparam int ValW         = 16;
  localparam int MaxChannel   = 16;

  localparam logic [ValW-1:0] PickupReset = 16'd1638;
  localparam logic [ValW-1:0] TolReset    = 16'd33;

  localparam logic CfgPickup = 1'b0;
  localparam logic CfgTol    = 1'b1;

  typedef enum logic [2:0] {
    FN_MSG    = 3'd0,
    FN_LEARN  = 3'd1,
    FN_CANCEL = 3'd2,
    FN_SET    = 3'd3,
    FN_REMOVE = 3'd4,
    FN_CLEAR  = 3'd5,
    FN_QUERY  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_NOMAP  = 2'd2
  } status_e;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] param;
  } owner_t;

  typedef owner_t [ChannelSlots-1:0] row_t;

  typedef struct packed {
    logic            latched;
    logic            lp_none;
    logic [ValW-1:0] lp;
    logic            lv_none;
    logic [ValW-1:0] lv;
  } tk_t;

  typedef struct packed {
    logic [CcW-1:0] cc;
    logic [ChW-1:0] ch;
    tk_t            tk;
  } pentry_t;

  localparam tk_t TkReset = '{latched: 1'b0, lp_none: 1'b1, lp: '0, lv_none: 1'b1, lv: '0};

  function automatic logic [ValW-1:0] absdiff(logic [ValW-1:0] a, logic [ValW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // round(c * 32768 / 127) = 258c + floor((2c + 63) / 127)
  function automatic logic [ValW-1:0] scale_cc(logic [CcW-1:0] c);
    logic [8:0] t;
    logic [1:0] r;
    t = {1'b0, c, 1'b0} + 9'd63;
    r = (t >= 9'd254) ? 2'd2 : ((t >= 9'd127) ? 2'd1 : 2'd0);
    return ValW'(c) * 16'd258 + ValW'(r);
  endfunction

endpackage

[hdl/mcl_ram.sv]
// generic simple dual-port ram with registered read
module mcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mcl_takeover.sv]
// soft takeover decision for one mapped parameter
module mcl_takeover
  import mcl_pkg::*;
(
  input  tk_t             tk_i,
  input  logic [ValW-1:0] cur_i,
  input  logic [ValW-1:0] val_i,
  input  logic [ValW-1:0] window_i,
  input  logic [ValW-1:0] tol_i,
  output tk_t             tk_o,
  output logic            write_o
);

  logic lat0;
  logic up;
  logic down;
  logic near;

  always_comb begin
    tk_o = tk_i;
    lat0 = tk_i.latched;
    if (tk_i.latched && !tk_i.lv_none && (absdiff(cur_i, tk_i.lv) > tol_i)) begin
      lat0 = 1'b0;
    end
    up   = (tk_i.lp <= cur_i) && (val_i >= cur_i);
    down = (tk_i.lp >= cur_i) && (val_i <= cur_i);
    near = absdiff(val_i, cur_i) < window_i;
    tk_o.latched = lat0;
    if (!lat0) begin
      if (!tk_i.lp_none && (up || down || near)) begin
        tk_o.latched = 1'b1;
      end
      tk_o.lp_none = 1'b0;
      tk_o.lp      = val_i;
    end
    if (tk_o.latched) begin
      tk_o.lv_none = 1'b0;
      tk_o.lv      = val_i;
    end
    write_o = tk_o.latched;
  end

endmodule

[hdl/midi_cc_learn_takeover.sv]
// Controller learn map with soft takeover. One request is taken when start is high and busy
// is low; its single result appears on the output ports for one cycle with done_o high and
// must be taken then. Learn, cancel, clear, rejected requests and unmapped removes or queries
// finish from idle; a mapped query reads the parameter ram in S_PRD; a controller message
// reads its slot row in S_MRD and updates an owner it finds in S_TRD; a remove goes S_PRD,
// S_ORD; a set or learn binding goes S_PRD, S_NRD, plus S_ORD and S_NREQ between if it
// drops the parameter's old slot. These follow from the single read port of the slot-row ram
// (128 rows of 17 owners) and of the per-parameter ram, each read once per step and written
// back after. Clear all and reset act on valid bits at once; no clearing pass is needed.
module midi_cc_learn_takeover
  import mcl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             func_i,
  input  logic [6:0]             cc_number_i,
  input  logic [4:0]             midi_channel_i,
  input  logic [6:0]             cc_value_i,
  input  logic [7:0]             param_index_i,
  input  logic [15:0]            current_value_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [15:0]            cfg_wdata_i,
  output logic                   done_o,
  output logic                   param_write_o,
  output logic [7:0]             write_param_o,
  output logic [15:0]            write_value_o,
  output logic                   learned_o,
  output logic signed [7:0]      mapped_cc_o,
  output logic [1:0]             status_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PRD  = 7'b0000010,
    S_ORD  = 7'b0000100,
    S_NREQ = 7'b0001000,
    S_NRD  = 7'b0010000,
    S_MRD  = 7'b0100000,
    S_TRD  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic          set_en;
    logic [PW-1:0] set_idx;
    logic          clr_en;
    logic [PW-1:0] clr_idx;
    logic          clr_all;
  } pv_ctl_t;

  state_e state_q, state_d;

  logic [ValW-1:0] pickup_q, tol_q;
  logic            learn_active_q, learn_active_d;
  logic [PW-1:0]   learn_target_q, learn_target_d;
  logic [NumCc-1:0]     row_valid_q;
  logic [NumParams-1:0] pvalid_q;

  func_e           func_q;
  logic            learn_bind_q;
  logic [PW-1:0]   bind_p_q;
  logic [CcW-1:0]  cc_q, old_cc_q;
  logic [ChW-1:0]  ch_q, old_ch_q;
  logic [ValW-1:0] val_q, cur_q;
  logic [PW-1:0]   owner_q;

  logic            accept;
  logic            fin;
  logic            res_wr, res_lrn;
  logic [PW-1:0]   res_wp;
  logic [ValW-1:0] res_wv;
  logic [7:0]      res_mcc;
  status_e         res_st;

  logic            rv_set_en;
  logic [CcW-1:0]  rv_set_idx;
  logic            rv_clr_all;
  pv_ctl_t         pv_ctl;

  logic            s_we;
  logic [CcW-1:0]  s_waddr, s_raddr;
  row_t            s_wdata, s_rdata;
  logic            p_we;
  logic [PW-1:0]   p_waddr, p_raddr;
  pentry_t         p_wdata, p_rdata;

  tk_t             tk_in, tk_out;
  logic            tk_write;
  logic            p_ok;

  mcl_ram #(.WIDTH($bits(row_t)), .DEPTH(NumCc)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  mcl_ram #(.WIDTH($bits(pentry_t)), .DEPTH(NumParams)) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // a valid owner was always written with a fresh takeover state when bound
  assign tk_in = p_rdata.tk;

  mcl_takeover u_takeover (
    .tk_i     (tk_in),
    .cur_i    (cur_q),
    .val_i    (val_q),
    .window_i (pickup_q),
    .tol_i    (tol_q),
    .tk_o     (tk_out),
    .write_o  (tk_write)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign p_ok   = int'(param_index_i) < NumParams;

  always_comb begin
    row_t   row;
    owner_t ent;
    state_d        = state_q;
    learn_active_d = learn_active_q;
    learn_target_d = learn_target_q;
    fin            = 1'b0;
    res_wr         = 1'b0;
    res_lrn        = 1'b0;
    res_wp         = '0;
    res_wv         = '0;
    res_mcc        = '0;
    res_st         = ST_DONE;
    rv_set_en      = 1'b0;
    rv_set_idx     = cc_q;
    rv_clr_all     = 1'b0;
    pv_ctl         = '0;
    s_we           = 1'b0;
    s_waddr        = cc_q;
    s_wdata        = '0;
    s_raddr        = cc_q;
    p_we           = 1'b0;
    p_waddr        = bind_p_q;
    p_wdata        = '0;
    p_raddr        = bind_p_q;
    row            = '0;
    ent            = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FN_MSG: begin
              if (learn_active_q) begin
                learn_active_d = 1'b0;
                learn_target_d = '0;
                p_raddr        = learn_target_q;
                state_d        = S_PRD;
              end else begin
                s_raddr = cc_number_i;
                state_d = S_MRD;
              end
            end
            FN_LEARN: begin
              fin = 1'b1;
              if (!p_ok) begin
                res_st = ST_REJECT;
              end else begin
                learn_active_d = 1'b1;
                learn_target_d = param_index_i;
              end
            end
            FN_CANCEL: begin
              fin            = 1'b1;
              learn_active_d = 1'b0;
              learn_target_d = '0;
            end
            FN_SET: begin
              if (!p_ok || (int'(midi_channel_i) > MaxChannel)) begin
                fin    = 1'b1;
                res_st = ST_REJECT;
              end else begin
                p_raddr = param_index_i;
                state_d = S_PRD;
              end
            end
            FN_REMOVE: begin
              if (!p_ok) begin
                fin    = 1'b1;
                res_st = ST_REJECT;
              end else if (!pvalid_q[param_index_i]) begin
                fin    = 1'b1;
                res_st = ST_NOMAP;
              end else begin
                p_raddr = param_index_i;
                state_d = S_PRD;
              end
            end
            FN_CLEAR: begin
              fin        = 1'b1;
              rv_clr_all = 1'b1;
              pv_ctl.clr_all = 1'b1;
            end
            FN_QUERY: begin
              if (!p_ok) begin
                fin    = 1'b1;
                res_st = ST_REJECT;
              end else if (!pvalid_q[param_index_i]) begin
                fin     = 1'b1;
                res_st  = ST_NOMAP;
                res_mcc = '1;
              end else begin
                p_raddr = param_index_i;
                state_d = S_PRD;
              end
            end
            default: begin
              fin    = 1'b1;
              res_st = ST_REJECT;
            end
          endcase
        end
      end
      S_PRD: begin
        case (func_q)
          FN_QUERY: begin
            fin     = 1'b1;
            res_mcc = {1'b0, p_rdata.cc};
            state_d = S_IDLE;
          end
          FN_REMOVE: begin
            pv_ctl.clr_en  = 1'b1;
            pv_ctl.clr_idx = bind_p_q;
            s_raddr        = p_rdata.cc;
            state_d        = S_ORD;
          end
          default: begin
            if (pvalid_q[bind_p_q]) begin
              pv_ctl.clr_en  = 1'b1;
              pv_ctl.clr_idx = bind_p_q;
              s_raddr        = p_rdata.cc;
              state_d        = S_ORD;
            end else begin
              s_raddr = cc_q;
              state_d = S_NRD;
            end
          end
        endcase
      end
      S_ORD: begin
        row           = row_valid_q[old_cc_q] ? s_rdata : '0;
        row[old_ch_q] = '0;
        s_we          = 1'b1;
        s_waddr       = old_cc_q;
        s_wdata       = row;
        rv_set_en     = 1'b1;
        rv_set_idx    = old_cc_q;
        if (func_q == FN_REMOVE) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_NREQ;
        end
      end
      S_NREQ: begin
        s_raddr = cc_q;
        state_d = S_NRD;
      end
      S_NRD: begin
        row = row_valid_q[cc_q] ? s_rdata : '0;
        ent = row[ch_q];
        if (ent.valid && (ent.param != bind_p_q)) begin
          pv_ctl.clr_en  = 1'b1;
          pv_ctl.clr_idx = ent.param;
        end
        row[ch_q]      = '{valid: 1'b1, param: bind_p_q};
        s_we           = 1'b1;
        s_wdata        = row;
        rv_set_en      = 1'b1;
        p_we           = 1'b1;
        p_wdata        = '{cc: cc_q, ch: ch_q, tk: TkReset};
        pv_ctl.set_en  = 1'b1;
        pv_ctl.set_idx = bind_p_q;
        fin            = 1'b1;
        res_lrn        = learn_bind_q;
        res_wp         = learn_bind_q ? bind_p_q : '0;
        state_d        = S_IDLE;
      end
      S_MRD: begin
        row = row_valid_q[cc_q] ? s_rdata : '0;
        ent = row[0];
        if (!ent.valid) begin
          fin     = 1'b1;
          res_st  = ST_NOMAP;
          state_d = S_IDLE;
        end else begin
          p_raddr = ent.param;
          state_d = S_TRD;
        end
      end
      S_TRD: begin
        p_we        = 1'b1;
        p_waddr     = owner_q;
        p_wdata     = '{cc: p_rdata.cc, ch: p_rdata.ch, tk: tk_out};
        fin         = 1'b1;
        res_wr      = tk_write;
        res_wp      = tk_write ? owner_q : '0;
        res_wv      = tk_write ? val_q : '0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      learn_active_q <= 1'b0;
      learn_target_q <= '0;
      row_valid_q    <= '0;
      pvalid_q       <= '0;
      done_o         <= 1'b0;
      pickup_q       <= PickupReset;
      tol_q          <= TolReset;
    end else begin
      state_q        <= state_d;
      learn_active_q <= learn_active_d;
      learn_target_q <= learn_target_d;
      done_o         <= fin;
      if (rv_clr_all) begin
        row_valid_q <= '0;
      end else if (rv_set_en) begin
        row_valid_q[rv_set_idx] <= 1'b1;
      end
      if (pv_ctl.clr_all) begin
        pvalid_q <= '0;
      end else begin
        if (pv_ctl.clr_en) begin
          pvalid_q[pv_ctl.clr_idx] <= 1'b0;
        end
        if (pv_ctl.set_en) begin
          pvalid_q[pv_ctl.set_idx] <= 1'b1;
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgPickup: pickup_q <= cfg_wdata_i;
          CfgTol:    tol_q    <= cfg_wdata_i;
          default:   pickup_q <= pickup_q;
        endcase
      end
    end
  end

  // request payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q       <= func_e'(func_i);
      learn_bind_q <= (func_e'(func_i) == FN_MSG) && learn_active_q;
      bind_p_q     <= ((func_e'(func_i) == FN_MSG) && learn_active_q) ? learn_target_q
                                                                     : param_index_i;
      cc_q         <= cc_number_i;
      ch_q         <= (func_e'(func_i) == FN_MSG) ? '0 : midi_channel_i;
      val_q        <= scale_cc(cc_value_i);
      cur_q        <= current_value_i;
    end
    if (state_q == S_PRD) begin
      old_cc_q <= p_rdata.cc;
      old_ch_q <= p_rdata.ch;
    end
    if (state_q == S_MRD) begin
      owner_q <= s_rdata[0].param;
    end
    if (fin) begin
      param_write_o <= res_wr;
      write_param_o <= res_wp;
      write_value_o <= res_wv;
      learned_o     <= res_lrn;
      mapped_cc_o   <= res_mcc;
      status_o      <= res_st;
    end
  end

endmodule

[hdl/midi_cc_learn_takeover_chk.sv]
// port-level checker for the controller learn map, bound to the top level
`include "midi_cc_learn_takeover_assert.svh"

module midi_cc_learn_takeover_chk
  import mcl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic              param_write_o,
  input logic              learned_o,
  input logic [1:0]        status_o
);

  logic reject_w;

  assign reject_w = done_o && (status_o == ST_REJECT);

  `MCL_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o)
  `MCL_ASSERT_NOW(a_learn_no_write, clk_i, rst_ni, done_o, !(param_write_o && learned_o))
  `MCL_ASSERT_NOW(a_write_is_done, clk_i, rst_ni, done_o && param_write_o, status_o == ST_DONE)
  `MCL_ASSERT_NOW(a_reject_quiet, clk_i, rst_ni, reject_w, !param_write_o && !learned_o)

endmodule

bind midi_cc_learn_takeover midi_cc_learn_takeover_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .param_write_o (param_write_o),
  .learned_o     (learned_o),
  .status_o      (status_o)
);
